// File: rtl/core/point_cloud_to_polar_scan_binning_core_defines.svh
// ============================================================================
// Assertion macros for the polar scan binning core
// Shared property forms used by the checker; sampled on clk, off in reset.
// ============================================================================
`ifndef POINT_CLOUD_TO_POLAR_SCAN_BINNING_CORE_DEFINES_SVH
`define POINT_CLOUD_TO_POLAR_SCAN_BINNING_CORE_DEFINES_SVH

// Same-cycle implication.
`define PCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pcb_pkg.sv
// ============================================================================
// pcb_pkg
// Types, constants and the arctangent table of the polar scan binning core.
// ============================================================================
package pcb_pkg;

    localparam int COORD_W    = 20;
    localparam int RANGE_W    = 20;
    localparam int ANGLE_W    = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int BIN_IDX_W  = 9;
    localparam int ADDR_MAX_W = 12;
    localparam int ATAN_IDX_W = 5;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_Z_FLOOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_CEILING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ANGLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VALUE = 3'd7;

    // CORDIC gain 0.60725293500888 in Q30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    typedef struct packed {
        logic                        command;
        logic signed [COORD_W-1:0]   point_x;
        logic signed [COORD_W-1:0]   point_y;
        logic signed [COORD_W-1:0]   point_z;
        logic        [BIN_IDX_W-1:0] bin_index;
    } pcb_in_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_value;
        logic               bin_hit;
    } pcb_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z_floor;
        logic signed [COORD_W-1:0] z_ceiling;
        logic        [RANGE_W-1:0] min_range;
        logic        [RANGE_W-1:0] max_range;
        logic signed [ANGLE_W-1:0] first_angle;
        logic signed [ANGLE_W-1:0] last_angle;
        logic        [ANGLE_W-1:0] angle_step;
        logic        [RANGE_W-1:0] empty_value;
    } pcb_cfg_t;

    // One operation handed from the front to the back.
    typedef struct packed {
        logic                  is_read;
        logic                  out_of_range;
        logic [ADDR_MAX_W-1:0] addr;
        logic [RANGE_W-1:0]    rng;
    } pcb_op_t;

    localparam pcb_cfg_t CFG_RESET = '{
        z_floor:     -20'sd2000,
        z_ceiling:   20'sd0,
        min_range:   20'd10,
        max_range:   20'd100000,
        first_angle: -16'sd32751,
        last_angle:  16'sd32751,
        angle_step:  16'd182,
        empty_value: 20'd1048575
    };

    // atan(2^-i) with pi = 2^31.
    function automatic logic [29:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/point_cloud_to_polar_scan_binning_core.sv
// Read command: registered in the front, queued, then the back reads the bin
// and registers the result; the front takes no new command until it is queued.
// Point command: one CORDIC rotation and one quotient bit per cycle in front,
// then bin read-modify-write in back. After reset all bins clear; input stalls.
// Configuration registers reset to their documented defaults.
// ============================================================================
// point_cloud_to_polar_scan_binning_core
// Bins 3D points into a planar scan keeping the minimum range per bearing bin.
// ============================================================================
module point_cloud_to_polar_scan_binning_core #(
    parameter int NUM_BINS      = 512,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pcb_pkg::pcb_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pcb_pkg::pcb_out_t              out_data,
    input  logic                           cfg_wr_en,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    pcb_pkg::pcb_cfg_t cfg_reg, cfg_next;
    logic              push, q_full, pop, q_empty, clearing;
    pcb_pkg::pcb_op_t  push_op, pop_op;

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pcb_pkg::CFG_Z_FLOOR:     cfg_next.z_floor     = $signed(cfg_data);
                pcb_pkg::CFG_Z_CEILING:   cfg_next.z_ceiling   = $signed(cfg_data);
                pcb_pkg::CFG_MIN_RANGE:   cfg_next.min_range   = cfg_data;
                pcb_pkg::CFG_MAX_RANGE:   cfg_next.max_range   = cfg_data;
                pcb_pkg::CFG_FIRST_ANGLE: cfg_next.first_angle = $signed(cfg_data[15:0]);
                pcb_pkg::CFG_LAST_ANGLE:  cfg_next.last_angle  = $signed(cfg_data[15:0]);
                pcb_pkg::CFG_ANGLE_STEP:  cfg_next.angle_step  = cfg_data[15:0];
                pcb_pkg::CFG_EMPTY_VALUE: cfg_next.empty_value = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pcb_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcb_front #(
        .NUM_BINS      (NUM_BINS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .push     (push),
        .push_op  (push_op),
        .q_full   (q_full)
    );

    pcb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (q_empty)
    );

    pcb_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty_value (cfg_reg.empty_value),
        .q_empty     (q_empty),
        .q_op        (pop_op),
        .pop         (pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// File: rtl/core/pcb_ram.sv
// ============================================================================
// pcb_ram
// Generic single write, single read RAM with registered read data.
// ============================================================================
module pcb_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/pcb_front.sv
// ============================================================================
// pcb_front
// Accepts commands, filters points and runs CORDIC, range scaling and the
// bin division; pushes one bin operation per surviving item into the queue.
// ============================================================================
module pcb_front #(
    parameter int NUM_BINS      = 512,
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  logic              in_valid,
    output logic              in_stall,
    input  pcb_pkg::pcb_in_t  in_data,
    input  pcb_pkg::pcb_cfg_t cfg,
    output logic              push,
    output pcb_pkg::pcb_op_t  push_op,
    input  logic              q_full
);

    localparam int CNT_W = $clog2(CORDIC_STAGES);
    localparam int AIW   = pcb_pkg::ATAN_IDX_W;
    localparam int AMW   = pcb_pkg::ADDR_MAX_W;

    typedef enum logic [6:0] {
        F_IDLE   = 7'b0000001,
        F_CORDIC = 7'b0000010,
        F_MUL    = 7'b0000100,
        F_CHECK  = 7'b0001000,
        F_DIV    = 7'b0010000,
        F_DONE   = 7'b0100000,
        F_PUSH   = 7'b1000000
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [33:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               zero_reg, zero_next;
    logic [60:0]        prod_reg, prod_next;
    logic signed [17:0] ang_reg, ang_next;
    logic [15:0]        dist_reg, dist_next;
    logic [15:0]        quo_reg, quo_next;
    logic [16:0]        rem_reg, rem_next;
    logic [3:0]         div_cnt_reg, div_cnt_next;
    pcb_pkg::pcb_op_t   op_reg, op_next;

    logic signed [31:0] xs, ys, dx, dy;
    logic signed [33:0] atan_s, acc_round;
    logic [60:0]        rng_round;
    logic [22:0]        rng_full;
    logic signed [17:0] ang_eff, lo_a, hi_a, d_full;
    logic signed [16:0] span;
    logic [15:0]        step;
    logic [16:0]        trial;
    logic               fits;

    assign in_stall = (state_reg != F_IDLE) || hold;
    assign push     = (state_reg == F_PUSH) && !q_full;
    assign push_op  = op_reg;

    // Shared arithmetic of the CORDIC, range and bin steps.
    always_comb
    begin
        xs        = {{12{in_data.point_x[19]}}, in_data.point_x};
        ys        = {{12{in_data.point_y[19]}}, in_data.point_y};
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        atan_s    = $signed({4'b0, pcb_pkg::atan_entry(AIW'(cnt_reg))});
        acc_round = acc_reg + 34'sd32768;
        rng_round = prod_reg + (61'd1 << 37);
        rng_full  = zero_reg ? 23'd0 : rng_round[60:38];
        ang_eff   = zero_reg ? 18'sd0 : ang_reg;
        lo_a      = {{2{cfg.first_angle[15]}}, cfg.first_angle};
        hi_a      = {{2{cfg.last_angle[15]}}, cfg.last_angle};
        d_full    = ang_eff - lo_a;
        span      = {cfg.last_angle[15], cfg.last_angle}
                    - {cfg.first_angle[15], cfg.first_angle};
        step      = (cfg.angle_step == 16'd0) ? 16'd1 : cfg.angle_step;
        trial     = {rem_reg[15:0], quo_reg[15]};
        fits      = (32'(quo_reg) < NUM_BINS)
                    && !(({1'b0, dist_reg} == span) && (rem_reg == 17'd0));
    end

    // Sequencer of one item.
    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        zero_next    = zero_reg;
        prod_next    = prod_reg;
        ang_next     = ang_reg;
        dist_next    = dist_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        op_next      = op_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && !hold)
                begin
                    if (in_data.command == pcb_pkg::CMD_READ)
                    begin
                        op_next.is_read      = 1'b1;
                        op_next.out_of_range = 32'(in_data.bin_index) >= NUM_BINS;
                        op_next.addr         = AMW'(in_data.bin_index);
                        op_next.rng          = '0;
                        state_next           = F_PUSH;
                    end
                    else if ((in_data.point_z <= cfg.z_ceiling)
                             && (in_data.point_z >= cfg.z_floor))
                    begin
                        zero_next = (xs == 32'sd0) && (ys == 32'sd0);
                        if (xs < 32'sd0)
                        begin
                            x_next   = (-xs) <<< 8;
                            y_next   = (-ys) <<< 8;
                            acc_next = (ys >= 32'sd0) ? 34'sd2147483648
                                                      : -34'sd2147483648;
                        end
                        else
                        begin
                            x_next   = xs <<< 8;
                            y_next   = ys <<< 8;
                            acc_next = 34'sd0;
                        end
                        cnt_next   = '0;
                        state_next = F_CORDIC;
                    end
                end
            end
            F_CORDIC:
            begin
                // One rotation toward the x axis per cycle.
                if (y_reg < 32'sd0)
                begin
                    x_next   = x_reg - dx;
                    y_next   = y_reg + dy;
                    acc_next = acc_reg - atan_s;
                end
                else
                begin
                    x_next   = x_reg + dx;
                    y_next   = y_reg - dy;
                    acc_next = acc_reg + atan_s;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STAGES - 1))
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                prod_next  = 61'(x_reg[30:0]) * 61'(pcb_pkg::GAIN_Q30);
                ang_next   = acc_round[33:16];
                state_next = F_CHECK;
            end
            F_CHECK:
            begin
                // Range and bearing windows.
                if ((rng_full > {3'b0, cfg.max_range}) || (rng_full < {3'b0, cfg.min_range})
                    || (ang_eff > hi_a) || (ang_eff < lo_a))
                begin
                    state_next = F_IDLE;
                end
                else
                begin
                    op_next.is_read      = 1'b0;
                    op_next.out_of_range = 1'b0;
                    op_next.rng          = rng_full[19:0];
                    dist_next            = d_full[15:0];
                    quo_next             = d_full[15:0];
                    rem_next             = '0;
                    div_cnt_next         = '0;
                    state_next           = F_DIV;
                end
            end
            F_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (trial >= {1'b0, step})
                begin
                    rem_next = trial - {1'b0, step};
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                op_next.addr = quo_reg[AMW-1:0];
                state_next   = fits ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        zero_reg    <= zero_next;
        prod_reg    <= prod_next;
        ang_reg     <= ang_next;
        dist_reg    <= dist_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        op_reg      <= op_next;
    end

endmodule

// File: rtl/core/pcb_queue.sv
// ============================================================================
// pcb_queue
// Two-entry queue of bin operations between the front and the back.
// ============================================================================
module pcb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pcb_pkg::pcb_op_t push_op,
    output logic             full,
    input  logic             pop,
    output pcb_pkg::pcb_op_t pop_op,
    output logic             empty
);

    pcb_pkg::pcb_op_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign pop_op = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: rtl/core/pcb_back.sv
// ============================================================================
// pcb_back
// Carries out bin operations on the bin memory: minimum update for points,
// read and clear for read commands. Clears the memory after reset.
// ============================================================================
module pcb_back #(
    parameter int NUM_BINS = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pcb_pkg::RANGE_W-1:0] empty_value,
    input  logic                        q_empty,
    input  pcb_pkg::pcb_op_t            q_op,
    output logic                        pop,
    output logic                        clearing,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pcb_pkg::pcb_out_t           out_data
);

    localparam int BW = $clog2(NUM_BINS);
    localparam int RW = pcb_pkg::RANGE_W;

    typedef enum logic [2:0] {
        B_CLEAR  = 3'b001,
        B_IDLE   = 3'b010,
        B_ACCESS = 3'b100
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [BW-1:0]     clr_cnt_reg, clr_cnt_next;
    pcb_pkg::pcb_op_t  cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    pcb_pkg::pcb_out_t out_data_reg, out_data_next;

    logic              wr_en, rd_en, out_free;
    logic [BW-1:0]     wr_addr;
    logic [RW:0]       wr_data, rd_data;
    logic              occ;
    logic [RW-1:0]     stored;

    // Each entry holds the occupied flag above the minimum range.
    pcb_ram #(
        .WIDTH (RW + 1),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (q_op.addr[BW-1:0]),
        .rd_data (rd_data)
    );

    assign occ       = rd_data[RW];
    assign stored    = rd_data[RW-1:0];
    assign out_free  = !out_valid_reg || !out_stall;
    assign clearing  = (state_reg == B_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Operation sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.addr[BW-1:0];
        wr_data        = '0;
        unique case (state_reg)
            B_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BW'(NUM_BINS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_op.is_read && q_op.out_of_range)
                    begin
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '{range_value: empty_value, bin_hit: 1'b0};
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        rd_en      = 1'b1;
                        cur_next   = q_op;
                        state_next = B_ACCESS;
                    end
                end
            end
            B_ACCESS:
            begin
                if (cur_reg.is_read)
                begin
                    // Report the bin, then mark it empty.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{range_value: occ ? stored : empty_value,
                                          bin_hit: occ};
                        wr_en          = 1'b1;
                        wr_data        = {1'b0, stored};
                        state_next     = B_IDLE;
                    end
                end
                else
                begin
                    // Keep the smaller range.
                    if (!occ || (cur_reg.rng < stored))
                    begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, cur_reg.rng};
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/pcb_checker.sv
// ============================================================================
// pcb_checker
// Port-level checks of the binning core, bound to the top level.
// ============================================================================
`include "point_cloud_to_polar_scan_binning_core_defines.svh"

module pcb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input pcb_pkg::pcb_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input pcb_pkg::pcb_out_t out_data
);

    logic [2:0] pending_reg, pending_next;
    logic       rd_in, rd_out;

    // Read commands taken but not yet answered.
    assign rd_in  = in_valid && !in_stall && (in_data.command == pcb_pkg::CMD_READ);
    assign rd_out = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg + {2'b0, rd_in} - {2'b0, rd_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `PCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result changed")
    `PCB_ASSERT_NOW(a_clear_stall, !$past(rst_n), in_stall,
        "input taken during the bin clearing pass")
    `PCB_ASSERT_NOW(a_no_invented, out_valid, pending_reg != 3'd0,
        "result without an outstanding read command")
    `PCB_ASSERT_NOW(a_pending_bound, 1'b1, pending_reg <= 3'd5,
        "more read commands in flight than the core can hold")

endmodule

bind point_cloud_to_polar_scan_binning_core pcb_checker u_checker (.*);

// File: test/pcb_scan_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Polar scan binning checker
// Watches the input, output and configuration ports of the binning core,
// predicts every read result from its own copy of the bins, and compares.
// ============================================================================
module pcb_scan_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  pcb_pkg::pcb_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  pcb_pkg::pcb_out_t              out_data,
    input  logic                           cfg_wr_en,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam int NBINS  = 512;
    localparam int STAGES = 16;
    localparam int RW     = pcb_pkg::RANGE_W;
    localparam longint ARC_TAB [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Shadow configuration and bin contents.
    longint              lo_height, hi_height, lo_range, hi_range;
    longint              lo_angle, hi_angle, bin_width, empty_range;
    logic [RW-1:0]       bin_min [NBINS];
    bit                  bin_full [NBINS];
    pcb_pkg::pcb_out_t   read_results [$];

    // Planar range and bearing by vectoring CORDIC.
    function automatic void polar_of(input longint px, input longint py,
                                     output longint rng, output longint ang);
        longint x, y, acc, dx, dy;
        acc = 0;
        x   = px;
        y   = py;
        if (x == 0 && y == 0)
        begin
            rng = 0;
            ang = 0;
            return;
        end
        if (x < 0)
        begin
            acc = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                acc = acc - ARC_TAB[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                acc = acc + ARC_TAB[i];
            end
        end
        rng = (x * 64'sd652032874 + (64'sd1 <<< 37)) >>> 38;
        ang = (acc + 32768) >>> 16;
    endfunction

    // Fold one point into the shadow bins.
    function automatic void bin_point(input pcb_pkg::pcb_in_t it);
        longint rng, ang, span, count, idx, pz;
        pz    = it.point_z;
        span  = hi_angle - lo_angle;
        count = (span > 0) ? (span + bin_width - 1) / bin_width : 0;
        if (count > NBINS)
            count = NBINS;
        if (pz > hi_height || pz < lo_height)
            return;
        polar_of(longint'(it.point_x), longint'(it.point_y), rng, ang);
        if (rng > hi_range || rng < lo_range)
            return;
        if (ang > hi_angle || ang < lo_angle)
            return;
        idx = (ang - lo_angle) / bin_width;
        if (idx < 0 || idx >= count)
            return;
        if (!bin_full[idx] || rng < longint'(bin_min[idx]))
        begin
            bin_min[idx]  = rng[RW-1:0];
            bin_full[idx] = 1'b1;
        end
    endfunction

    // Sample all three ports on the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pcb_pkg::pcb_out_t want;
        if (!rst_n)
        begin
            lo_height   = pcb_pkg::CFG_RESET.z_floor;
            hi_height   = pcb_pkg::CFG_RESET.z_ceiling;
            lo_range    = pcb_pkg::CFG_RESET.min_range;
            hi_range    = pcb_pkg::CFG_RESET.max_range;
            lo_angle    = pcb_pkg::CFG_RESET.first_angle;
            hi_angle    = pcb_pkg::CFG_RESET.last_angle;
            bin_width   = pcb_pkg::CFG_RESET.angle_step;
            empty_range = pcb_pkg::CFG_RESET.empty_value;
            for (int i = 0; i < NBINS; i++)
                bin_full[i] = 1'b0;
            read_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pcb_pkg::CFG_Z_FLOOR:     lo_height   = $signed(cfg_data[19:0]);
                    pcb_pkg::CFG_Z_CEILING:   hi_height   = $signed(cfg_data[19:0]);
                    pcb_pkg::CFG_MIN_RANGE:   lo_range    = cfg_data[19:0];
                    pcb_pkg::CFG_MAX_RANGE:   hi_range    = cfg_data[19:0];
                    pcb_pkg::CFG_FIRST_ANGLE: lo_angle    = $signed(cfg_data[15:0]);
                    pcb_pkg::CFG_LAST_ANGLE:  hi_angle    = $signed(cfg_data[15:0]);
                    pcb_pkg::CFG_ANGLE_STEP:
                        bin_width = (cfg_data[15:0] == 0) ? 1 : cfg_data[15:0];
                    pcb_pkg::CFG_EMPTY_VALUE: empty_range = cfg_data[19:0];
                    default: ;
                endcase
            end
            // Output transfer against the oldest expected read.
            if (out_valid && !out_stall)
            begin
                if (read_results.size() == 0)
                begin
                    $error("unexpected output transfer: range_value %0d bin_hit %0d",
                           out_data.range_value, out_data.bin_hit);
                    fail_count++;
                end
                else
                begin
                    want = read_results.pop_front();
                    if (out_data.range_value !== want.range_value)
                    begin
                        $error("range_value: expected %0d, actual %0d",
                               want.range_value, out_data.range_value);
                        fail_count++;
                    end
                    if (out_data.bin_hit !== want.bin_hit)
                    begin
                        $error("bin_hit: expected %0d, actual %0d",
                               want.bin_hit, out_data.bin_hit);
                        fail_count++;
                    end
                end
            end
            // Input transfer: a read yields a result, a point updates bins.
            if (in_valid && !in_stall)
            begin
                if (in_data.command == pcb_pkg::CMD_READ)
                begin
                    want.range_value = empty_range[RW-1:0];
                    want.bin_hit     = 1'b0;
                    if (bin_full[in_data.bin_index])
                    begin
                        want.range_value = bin_min[in_data.bin_index];
                        want.bin_hit     = 1'b1;
                    end
                    bin_full[in_data.bin_index] = 1'b0;
                    read_results.push_back(want);
                end
                else
                    bin_point(in_data);
            end
            pending = read_results.size();
        end
    end
endmodule

// File: test/point_cloud_to_polar_scan_binning_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Polar scan binning core testbench
// Directed and random points and bin reads over several register settings,
// with random idle cycles on both channels; a checker does the scoring.
// ============================================================================
module point_cloud_to_polar_scan_binning_core_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    pcb_pkg::pcb_in_t               in_data;
    logic                           out_valid;
    logic                           out_stall;
    pcb_pkg::pcb_out_t              out_data;
    logic                           cfg_wr_en;
    logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending;
    int                             cycle_count;
    bit                             idle_on;
    int                             z_lo, z_hi;

    point_cloud_to_polar_scan_binning_core dut (.*);

    pcb_scan_checker u_scan_chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver side stalls at random.
    always @(negedge clk)
        out_stall <= idle_on && ($urandom_range(0, 99) < 13);

    // Offer one item and hold it until its transfer; valid stays high after.
    task automatic send_item(input pcb_pkg::pcb_in_t item);
        while (idle_on && ($urandom_range(0, 99) < 13))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        @(negedge clk);
    endtask

    function automatic pcb_pkg::pcb_in_t read_cmd(input int bin);
        pcb_pkg::pcb_in_t it;
        it = '{default: '0};
        it.command   = pcb_pkg::CMD_READ;
        it.point_x   = 20'($urandom());
        it.point_y   = 20'($urandom());
        it.point_z   = 20'($urandom());
        it.bin_index = 9'(bin);
        return it;
    endfunction

    function automatic pcb_pkg::pcb_in_t point_cmd(input int x, input int y, input int z);
        pcb_pkg::pcb_in_t it;
        it.command   = pcb_pkg::CMD_POINT;
        it.point_x   = 20'(x);
        it.point_y   = 20'(y);
        it.point_z   = 20'(z);
        it.bin_index = 9'($urandom());
        return it;
    endfunction

    // Wait for every read to return and for points still in the pipeline.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_regs(input int mh_lo, input int mh_hi, input int r_lo,
                              input int r_hi, input int a_lo, input int a_hi,
                              input int step, input int empty);
        int vals [8];
        vals = '{mh_lo, mh_hi, r_lo, r_hi, a_lo, a_hi, step, empty};
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= 20'(vals[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        z_lo = mh_lo;
        z_hi = mh_hi;
        @(negedge clk);
    endtask

    // Random traffic: mostly in-range points, reads, and some raw noise.
    task automatic random_phase(input int count);
        int pick, mag;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            mag  = ($urandom_range(0, 3) == 0) ? 524287 : 60000;
            if (pick < 35)
                send_item(read_cmd($urandom_range(0, 511)));
            else if (pick < 90)
                send_item(point_cmd($urandom_range(0, 2 * mag) - mag,
                                    $urandom_range(0, 2 * mag) - mag,
                                    z_lo + int'($urandom_range(0, z_hi - z_lo))));
            else
                send_item(point_cmd($urandom(), $urandom(), $urandom()));
        end
        // Sweep reads so filled bins get read back.
        for (int b = 0; b < 512; b += $urandom_range(1, 24))
            send_item(read_cmd(b));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_on     = 1'b1;
        z_lo        = -2000;
        z_hi        = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty read, origin, the pi bearing, height limits, extremes.
        write_regs(-2000, 0, 0, 100000, -32751, 32751, 182, 1048575);
        send_item(read_cmd(0));
        send_item(read_cmd(511));
        send_item(point_cmd(0, 0, -5));
        send_item(point_cmd(-1000, 0, -5));
        send_item(point_cmd(-1000, -1, -5));
        send_item(point_cmd(1000, 0, 1));
        send_item(point_cmd(1000, 0, -2001));
        send_item(point_cmd(1000, 0, -2000));
        send_item(point_cmd(900, 0, 0));
        send_item(point_cmd(524287, 524287, -1));
        send_item(point_cmd(-524288, -524288, -1));
        send_item(point_cmd(0, 50000, -1));
        send_item(point_cmd(0, -50000, -1));
        send_item(point_cmd(-3, 7, -1));
        send_item(read_cmd(180));
        send_item(read_cmd(179));
        send_item(read_cmd(180));
        send_item(read_cmd(0));
        send_item(read_cmd(270));
        send_item(read_cmd(90));
        send_item(read_cmd(90));
        send_item(read_cmd(359));
        send_item(read_cmd(360));
        drain();

        // Reset-like settings.
        write_regs(-2000, 0, 10, 100000, -32751, 32751, 182, 1048575);
        random_phase(120);
        drain();

        // Widest limits, 512 bins, no idling at all.
        idle_on = 1'b0;
        write_regs(-524288, 524287, 0, 1048575, -32768, 32767, 128, 0);
        random_phase(130);
        drain();
        idle_on = 1'b1;

        // Finest step: bin count capped, most bearings beyond the last bin.
        write_regs(-100, 100, 5, 70000, -32768, 32767, 1, 12345);
        random_phase(90);
        drain();

        // Zero step and a narrow sector.
        write_regs(-30000, 30000, 100, 50000, -600, 400, 0, 777);
        random_phase(90);
        drain();

        // Coarsest step: a single bin.
        write_regs(-524288, 524287, 0, 1048575, -32768, 32767, 65535, 1);
        random_phase(90);
        drain();

        // Empty sector: last angle at or below first angle.
        write_regs(-1000, 1000, 0, 1048575, 1000, 1000, 10, 524288);
        random_phase(60);
        drain();

        // Nothing passes the range gate.
        write_regs(524287, -524288, 1048575, 0, 32767, -32768, 65535, 1048575);
        random_phase(40);
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: point_cloud_to_polar_scan_binning_core.f
+incdir+rtl/core
rtl/core/pcb_pkg.sv
rtl/core/pcb_ram.sv
rtl/core/pcb_front.sv
rtl/core/pcb_queue.sv
rtl/core/pcb_back.sv
rtl/core/point_cloud_to_polar_scan_binning_core.sv
rtl/core/pcb_checker.sv
test/pcb_scan_checker.sv
test/point_cloud_to_polar_scan_binning_core_tb.sv
